// File: hdl/assert_macros.svh
// Assertion macros used by the filter unit.
// Used by the file that checks its own sequencing; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Never holds while out of reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// Implication checked at every edge while out of reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/kabf_pkg.sv
// Shared types, constants and saturating helpers for the angle and bias filter.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package kabf_pkg;

    localparam int FracDt   = 16;
    localparam int FracGain = 32;

    localparam logic [31:0] RESET_Q_ANGLE = 32'd4294967;
    localparam logic [31:0] RESET_Q_BIAS  = 32'd12884902;
    localparam logic [31:0] RESET_R_MEAS  = 32'd128849019;

    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] sum;
        sum = a + b;
        if (a[63] == b[63] && sum[63] != a[63]) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] dif;
        dif = a - b;
        if (a[63] != b[63] && dif[63] != a[63]) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return dif;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// File: hdl/kabf_mul_unit.sv
// Shared multiplier: signed 64 by 64 product, shifted right by 16 or 32 bits,
// truncated toward zero and saturated. Four 32 by 32 partial products. Uses kabf_pkg.
`timescale 1ns / 1ps

module kabf_mul_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [63:0]  op_a,
    input  logic signed [63:0]  op_b,
    input  logic                shift32,
    output logic signed [63:0]  result,
    output kabf_pkg::unit_status_t status
);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

    mstate_t             state_reg;
    logic [63:0]         ua_reg, ub_reg;
    logic                neg_reg, sh32_reg, done_reg;
    logic [127:0]        acc_reg;
    logic [1:0]          cnt_reg;
    logic signed [63:0]  res_reg;

    logic [31:0]  a_part, b_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh, shifted;
    logic [63:0]  hi, lo;
    logic signed [63:0] fin;

    always_comb begin
        a_part = cnt_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
        b_part = cnt_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
        pp = 64'(a_part) * 64'(b_part);
        unique case (cnt_reg)
            2'd0:       pp_sh = {64'd0, pp};
            2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
            default:    pp_sh = {pp, 64'd0};
        endcase
        shifted = sh32_reg ? (acc_reg >> kabf_pkg::FracGain) : (acc_reg >> kabf_pkg::FracDt);
        hi = shifted[127:64];
        lo = shifted[63:0];
        if (|hi) begin
            fin = neg_reg ? kabf_pkg::S64_MIN : kabf_pkg::S64_MAX;
        end else if (neg_reg) begin
            fin = lo[63] ? kabf_pkg::S64_MIN : -$signed(lo);
        end else begin
            fin = lo[63] ? kabf_pkg::S64_MAX : $signed(lo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        ua_reg    <= kabf_pkg::mag64(op_a);
                        ub_reg    <= kabf_pkg::mag64(op_b);
                        neg_reg   <= op_a[63] ^ op_b[63];
                        sh32_reg  <= shift32;
                        acc_reg   <= '0;
                        cnt_reg   <= 2'd0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN: begin
                    acc_reg <= acc_reg + pp_sh;
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN: begin
                    res_reg   <= fin;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign result      = res_reg;
    assign status.busy = (state_reg != M_IDLE);
    assign status.done = done_reg;

endmodule

// File: hdl/kabf_div_unit.sv
// Shared restoring divider: signed (n << 32) / d, one quotient bit a cycle,
// truncated toward zero and saturated; zero for a zero divisor. Uses kabf_pkg.
`timescale 1ns / 1ps

module kabf_div_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [63:0]  num,
    input  logic signed [63:0]  den,
    output logic signed [63:0]  result,
    output kabf_pkg::unit_status_t status
);

    localparam int NumBits = 64 + kabf_pkg::FracGain;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t              state_reg;
    logic [NumBits-1:0]   n_reg, q_reg;
    logic [63:0]          ud_reg, r_reg;
    logic                 neg_reg, done_reg;
    logic [6:0]           cnt_reg;
    logic signed [63:0]   res_reg;

    logic [64:0] r_sh;
    logic        fits;

    always_comb begin
        r_sh = {r_reg, n_reg[NumBits-1]};
        fits = (r_sh >= {1'b0, ud_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        n_reg     <= {kabf_pkg::mag64(num), 32'd0};
                        ud_reg    <= kabf_pkg::mag64(den);
                        neg_reg   <= num[63] ^ den[63];
                        r_reg     <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    n_reg <= {n_reg[NumBits-2:0], 1'b0};
                    r_reg <= fits ? 64'(r_sh - {1'b0, ud_reg}) : r_sh[63:0];
                    q_reg <= {q_reg[NumBits-2:0], fits};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(NumBits - 1)) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (ud_reg == 64'd0) begin
                        res_reg <= '0;
                    end else if (|q_reg[NumBits-1:63]) begin
                        res_reg <= neg_reg ? kabf_pkg::S64_MIN : kabf_pkg::S64_MAX;
                    end else begin
                        res_reg <= neg_reg ? -$signed(q_reg[63:0]) : $signed(q_reg[63:0]);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign result      = res_reg;
    assign status.busy = (state_reg != D_IDLE);
    assign status.done = done_reg;

endmodule

// File: hdl/kalman_angle_bias_filter_unit.sv
// A filter request takes ten multiplier passes, two subtract states, two divider passes
// and one output state. A request with set_angle high loads the measured angle and goes
// straight to the output state. The next request is accepted only after the result is loaded
// into the output register; the result register frees the input side. Reset (synchronous,
// aresetn low) clears the estimates and covariance and restores the noise defaults.
// Uses kabf_pkg, kabf_mul_unit, kabf_div_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kalman_angle_bias_filter_unit #(
    parameter int COV_WIDTH = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [24:0]  s_measured_angle,
    input  logic signed [27:0]  s_gyro_rate,
    input  logic [15:0]         s_time_step,
    input  logic                s_set_angle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_filtered_angle
);

    localparam logic signed [63:0] COV_MAX = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] COV_MIN = -COV_MAX - 64'sd1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_T1, ST_T2, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_ANGLE_ADV, STEP_DT_PBB, STEP_PAA_ADV, STEP_PBB_ADV, STEP_ANGLE_COR,
        STEP_BIAS_COR, STEP_PBA_UPD, STEP_PBB_UPD, STEP_PAA_UPD, STEP_PAB_UPD
    } step_t;

    function automatic logic signed [COV_WIDTH-1:0] sat_cov(input logic signed [63:0] v);
        if (v > COV_MAX) begin
            return COV_MAX[COV_WIDTH-1:0];
        end else if (v < COV_MIN) begin
            return COV_MIN[COV_WIDTH-1:0];
        end
        return v[COV_WIDTH-1:0];
    endfunction

    state_t  state_reg;
    step_t   step_reg;
    logic    div_sel_reg;

    logic [31:0] q_angle_reg, q_bias_reg, r_meas_reg;

    logic signed [31:0]          angle_reg, bias_reg;
    logic signed [COV_WIDTH-1:0] paa_reg, pab_reg, pba_reg, pbb_reg;

    logic signed [63:0] meas_reg, rate_reg, tb_reg, t_reg, y_reg, s_reg, k0_reg, k1_reg;
    logic [15:0]        dt_reg;

    logic                out_valid_reg;
    logic signed [31:0]  out_angle_reg;

    logic signed [63:0] angle64, bias64, paa64, pab64, pba64, pbb64, dt64;
    logic signed [63:0] mul_a, mul_b, mul_res, div_res;
    logic               mul_sh32;
    kabf_pkg::unit_status_t mul_st, div_st;

    assign angle64 = 64'(angle_reg);
    assign bias64  = 64'(bias_reg);
    assign paa64   = 64'(paa_reg);
    assign pab64   = 64'(pab_reg);
    assign pba64   = 64'(pba_reg);
    assign pbb64   = 64'(pbb_reg);
    assign dt64    = $signed({48'd0, dt_reg});

    always_comb begin
        mul_sh32 = 1'b1;
        unique case (step_reg)
            STEP_ANGLE_ADV: begin mul_a = dt64; mul_b = rate_reg; mul_sh32 = 1'b0; end
            STEP_DT_PBB:    begin mul_a = dt64; mul_b = pbb64;    mul_sh32 = 1'b0; end
            STEP_PAA_ADV:   begin mul_a = dt64; mul_b = t_reg;    mul_sh32 = 1'b0; end
            STEP_PBB_ADV: begin
                mul_a = $signed({32'd0, q_bias_reg});
                mul_b = dt64;
                mul_sh32 = 1'b0;
            end
            STEP_ANGLE_COR: begin mul_a = k0_reg; mul_b = y_reg; end
            STEP_BIAS_COR:  begin mul_a = k1_reg; mul_b = y_reg; end
            STEP_PBA_UPD:   begin mul_a = k1_reg; mul_b = paa64; end
            STEP_PBB_UPD:   begin mul_a = k1_reg; mul_b = pab64; end
            STEP_PAA_UPD:   begin mul_a = k0_reg; mul_b = paa64; end
            default:        begin mul_a = k0_reg; mul_b = pab64; end
        endcase
    end

    kabf_mul_unit u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_MUL_GO),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .shift32 (mul_sh32),
        .result  (mul_res),
        .status  (mul_st)
    );

    kabf_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIV_GO),
        .num     (div_sel_reg ? pba64 : paa64),
        .den     (s_reg),
        .result  (div_res),
        .status  (div_st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_angle_reg <= kabf_pkg::RESET_Q_ANGLE;
            q_bias_reg  <= kabf_pkg::RESET_Q_BIAS;
            r_meas_reg  <= kabf_pkg::RESET_R_MEAS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                kabf_pkg::REG_Q_ANGLE: q_angle_reg <= cfg_wdata;
                kabf_pkg::REG_Q_BIAS:  q_bias_reg  <= cfg_wdata;
                kabf_pkg::REG_R_MEAS:  r_meas_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_ANGLE_ADV;
            div_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            paa_reg       <= '0;
            pab_reg       <= '0;
            pba_reg       <= '0;
            pbb_reg       <= '0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        meas_reg <= 64'(s_measured_angle);
                        dt_reg   <= s_time_step;
                        rate_reg <= 64'(s_gyro_rate) - bias64;
                        step_reg <= STEP_ANGLE_ADV;
                        if (s_set_angle) begin
                            angle_reg <= 32'(s_measured_angle);
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL_GO;
                        end
                    end
                end
                ST_MUL_GO: state_reg <= ST_MUL_WAIT;
                ST_MUL_WAIT: begin
                    if (mul_st.done) begin
                        state_reg <= ST_MUL_GO;
                        unique case (step_reg)
                            STEP_ANGLE_ADV: begin
                                angle_reg <= kabf_pkg::sat32(kabf_pkg::sat_add(angle64, mul_res));
                                step_reg  <= STEP_DT_PBB;
                            end
                            STEP_DT_PBB: begin
                                tb_reg    <= mul_res;
                                t_reg     <= kabf_pkg::sat_sub(mul_res, pab64);
                                step_reg  <= STEP_PAA_ADV;
                                state_reg <= ST_T1;
                            end
                            STEP_PAA_ADV: begin
                                paa_reg  <= sat_cov(kabf_pkg::sat_add(paa64, mul_res));
                                y_reg    <= meas_reg - angle64;
                                step_reg <= STEP_PBB_ADV;
                            end
                            STEP_PBB_ADV: begin
                                pbb_reg     <= sat_cov(kabf_pkg::sat_add(pbb64, mul_res));
                                s_reg       <= kabf_pkg::sat_add(paa64,
                                                   $signed({32'd0, r_meas_reg}));
                                div_sel_reg <= 1'b0;
                                step_reg    <= STEP_ANGLE_COR;
                                state_reg   <= ST_DIV_GO;
                            end
                            STEP_ANGLE_COR: begin
                                angle_reg <= kabf_pkg::sat32(kabf_pkg::sat_add(angle64, mul_res));
                                step_reg  <= STEP_BIAS_COR;
                            end
                            STEP_BIAS_COR: begin
                                bias_reg <= kabf_pkg::sat32(kabf_pkg::sat_add(bias64, mul_res));
                                step_reg <= STEP_PBA_UPD;
                            end
                            STEP_PBA_UPD: begin
                                pba_reg  <= sat_cov(kabf_pkg::sat_sub(pba64, mul_res));
                                step_reg <= STEP_PBB_UPD;
                            end
                            STEP_PBB_UPD: begin
                                pbb_reg  <= sat_cov(kabf_pkg::sat_sub(pbb64, mul_res));
                                step_reg <= STEP_PAA_UPD;
                            end
                            STEP_PAA_UPD: begin
                                paa_reg  <= sat_cov(kabf_pkg::sat_sub(paa64, mul_res));
                                step_reg <= STEP_PAB_UPD;
                            end
                            default: begin
                                pab_reg   <= sat_cov(kabf_pkg::sat_sub(pab64, mul_res));
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_T1: begin
                    t_reg     <= kabf_pkg::sat_sub(t_reg, pba64);
                    pab_reg   <= sat_cov(kabf_pkg::sat_sub(pab64, tb_reg));
                    state_reg <= ST_T2;
                end
                ST_T2: begin
                    t_reg     <= kabf_pkg::sat_add(t_reg, $signed({32'd0, q_angle_reg}));
                    pba_reg   <= sat_cov(kabf_pkg::sat_sub(pba64, tb_reg));
                    state_reg <= ST_MUL_GO;
                end
                ST_DIV_GO: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_st.done) begin
                        if (div_sel_reg) begin
                            k1_reg    <= div_res;
                            state_reg <= ST_MUL_GO;
                        end else begin
                            k0_reg      <= div_res;
                            div_sel_reg <= 1'b1;
                            state_reg   <= ST_DIV_GO;
                        end
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_angle_reg <= angle_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_filtered_angle = out_angle_reg;

    `ASSERT_NEVER(a_idle_units_quiet, aclk, aresetn, s_ready && (mul_st.busy || div_st.busy), "request accepted while an arithmetic unit is busy")
    `ASSERT_IMPL(a_mul_done_waited, aclk, aresetn, mul_st.done, state_reg == ST_MUL_WAIT, "multiplier finished outside its wait state")
    `ASSERT_IMPL(a_div_done_waited, aclk, aresetn, div_st.done, state_reg == ST_DIV_WAIT, "divider finished outside its wait state")

endmodule
